// ----- hw/rtl/fraction_reduce_gcd_assert.svh -----
// Assertion macros shared by the fraction reduction RTL.
`ifndef FRACTION_REDUCE_GCD_ASSERT_SVH
`define FRACTION_REDUCE_GCD_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FRG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fraction_reduce_gcd: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FRG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fraction_reduce_gcd: next-cycle check failed");

`endif

// ----- hw/rtl/frg_pkg.sv -----
// Shared constants, types and controller/datapath interface structs.
package frg_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
    localparam int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // Operand selection for the shared divider
    typedef enum logic [1:0] {
        DIV_REM = 2'd0,
        DIV_QN  = 2'd1,
        DIV_QD  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     euclid_step;
        logic     save_qn;
        logic     write_out;
    } t_cmd;

    typedef struct packed {
        logic b_zero;
        logic a_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/fraction_reduce_gcd.sv -----
// Flow: from request accept to result valid, (k + 2) divisions run, k being the Euclid
//   remainder steps (at most 46 at 32 bits); none run when both inputs are zero.
// Occupancy: one item at a time; each remainder and both quotients run on one shared
//   bit-serial divider, and the next request can be accepted the cycle after the result
//   is written; that write waits while the result side stalls.
// Synchronous active-low reset clears the controller, divider control and output valid.
module fraction_reduce_gcd import frg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // num_in, den_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // num_out, den_out
    output logic               m_axis_tuser    // zero_error
);

    t_cmd    cmd;
    t_status status;
    t_word   num_out, den_out;

    frg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    frg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_data    (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_num_out    (num_out),
        .o_den_out    (den_out),
        .o_zero_error (m_axis_tuser)
    );

    // Pack result fields, zero fill to whole bytes
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[DATA_WIDTH-1:0]            = num_out;
        m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] = den_out;
    end

endmodule

// ----- hw/rtl/frg_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`include "fraction_reduce_gcd_assert.svh"

module frg_div import frg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_busy,
    output logic  o_done,
    output t_word o_quo,
    output t_word o_rem
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    t_word            r_rem,  n_rem;
    t_word            r_quo,  n_quo;
    t_word            r_dvs,  n_dvs;

    logic [DATA_WIDTH:0] rem_sh;
    logic [DATA_WIDTH:0] diff;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_quo[DATA_WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DATA_WIDTH);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[DATA_WIDTH]) begin
                n_rem = diff[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operand and result registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    `FRG_ASSERT_IMP(a_div_no_restart, r_busy, !i_start)
    `FRG_ASSERT_NXT(a_div_start_busy, i_start, r_busy && !r_done)
    `FRG_ASSERT_IMP(a_div_rem_below, r_done, r_rem < r_dvs)

endmodule

// ----- hw/rtl/frg_dp.sv -----
// Datapath: sign/magnitude operands, Euclid registers, divider, output register.
module frg_dp import frg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [TDATA_W-1:0]    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_word                 o_num_out,
    output t_word                 o_den_out,
    output logic                  o_zero_error
);

    logic  r_n_neg, r_d_neg, r_a_neg, r_b_neg;
    t_word r_n_mag, r_d_mag, r_a_mag, r_b_mag;
    t_word r_qn;
    logic  r_ovalid;
    t_word r_onum, r_oden;
    logic  r_oerr;

    t_word num_raw, den_raw;
    t_word div_dividend, div_divisor, div_quo, div_rem;
    logic  div_busy, div_done;
    logic  qn_neg, qd_neg;

    // Two's complement word to magnitude; the most negative value maps to 2^(W-1)
    function automatic t_word mag_of(input t_word raw);
        return raw[DATA_WIDTH-1] ? (t_word'(0) - raw) : raw;
    endfunction

    // Apply sign to a magnitude
    function automatic t_word signed_of(input logic neg, input t_word mag);
        return neg ? (t_word'(0) - mag) : mag;
    endfunction

    assign num_raw = i_in_data[DATA_WIDTH-1:0];
    assign den_raw = i_in_data[2*DATA_WIDTH-1:DATA_WIDTH];

    // Select divider operands: remainder a % b, or quotients by g
    always_comb begin
        case (i_cmd.div_sel)
            DIV_REM: begin
                div_dividend = r_a_mag;
                div_divisor  = r_b_mag;
            end
            DIV_QN: begin
                div_dividend = r_n_mag;
                div_divisor  = r_a_mag;
            end
            DIV_QD: begin
                div_dividend = r_d_mag;
                div_divisor  = r_a_mag;
            end
            default: begin
                div_dividend = r_a_mag;
                div_divisor  = r_b_mag;
            end
        endcase
    end

    frg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Load operands, advance Euclid, hold the numerator quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n_neg <= num_raw[DATA_WIDTH-1];
            r_n_mag <= mag_of(num_raw);
            r_d_neg <= den_raw[DATA_WIDTH-1];
            r_d_mag <= mag_of(den_raw);
            r_a_neg <= num_raw[DATA_WIDTH-1];
            r_a_mag <= mag_of(num_raw);
            r_b_neg <= den_raw[DATA_WIDTH-1];
            r_b_mag <= mag_of(den_raw);
        end else if (i_cmd.euclid_step) begin
            r_a_neg <= r_b_neg;
            r_a_mag <= r_b_mag;
            r_b_neg <= r_a_neg && (div_rem != '0);
            r_b_mag <= div_rem;
        end
        if (i_cmd.save_qn) begin
            r_qn <= div_quo;
        end
    end

    assign qn_neg = (r_n_neg != r_a_neg) && (r_qn != '0);
    assign qd_neg = (r_d_neg != r_a_neg) && (div_quo != '0);

    // Output register: valid until the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.write_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Zero gcd only when both inputs were zero, so the pass-through is zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_out) begin
            if (r_a_mag == '0) begin
                r_onum <= '0;
                r_oden <= '0;
                r_oerr <= 1'b1;
            end else begin
                r_onum <= signed_of(qn_neg, r_qn);
                r_oden <= signed_of(qd_neg, div_quo);
                r_oerr <= 1'b0;
            end
        end
    end

    assign o_status.b_zero   = (r_b_mag == '0);
    assign o_status.a_zero   = (r_a_mag == '0);
    assign o_status.div_busy = div_busy;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_num_out    = r_onum;
    assign o_den_out    = r_oden;
    assign o_zero_error = r_oerr;

endmodule

// ----- hw/rtl/frg_ctrl.sv -----
// Controller: load, Euclid steps, two divisions if gcd is nonzero, output.
`include "fraction_reduce_gcd_assert.svh"

module frg_ctrl import frg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_REM   = 6'b000100,
        S_QN    = 6'b001000,
        S_QD    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_REM;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.b_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_REM;
                    n_state         = S_REM;
                end else if (i_status.a_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_QN;
                    n_state         = S_QN;
                end
            end
            S_REM: begin
                if (i_status.div_done) begin
                    o_cmd.euclid_step = 1'b1;
                    n_state           = S_CHECK;
                end
            end
            S_QN: begin
                if (i_status.div_done) begin
                    o_cmd.save_qn   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_QD;
                    n_state         = S_QD;
                end
            end
            S_QD: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.write_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `FRG_ASSERT_IMP(a_ctrl_start_free, o_cmd.div_start, !i_status.div_busy)

endmodule

// ----- tb/sv/fraction_reduce_gcd_tb.sv -----
// Self-checking testbench for the streaming gcd fraction reducer.
module fraction_reduce_gcd_tb import frg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_WAIT  = 2000;   // longer than the slowest reduction
    localparam int MAX_GAP     = 6;

    typedef struct packed {
        t_word num;
        t_word den;
        logic  zero_err;
    } t_reduced;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;   // num_in, den_in
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // num_out, den_out
    logic               m_axis_tuser;   // zero_error

    t_reduced pending_reductions[$];
    int       n_requests;
    int       n_results;
    int       n_zero_flags;
    int       n_mismatches;
    bit       no_idle;

    fraction_reduce_gcd u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Euclid with truncating remainder, then truncating division by the signed gcd
    function automatic t_reduced reduce_fraction(t_word num, t_word den);
        t_reduced res;
        logic     n_neg, d_neg, a_neg, b_neg, r_neg;
        t_word    n_mag, d_mag, a_mag, b_mag, r_mag, q;
        n_neg = num[DATA_WIDTH-1];
        d_neg = den[DATA_WIDTH-1];
        n_mag = n_neg ? -num : num;
        d_mag = d_neg ? -den : den;
        a_neg = n_neg;
        a_mag = n_mag;
        b_neg = d_neg;
        b_mag = d_mag;
        while (b_mag != '0) begin
            r_mag = a_mag % b_mag;
            r_neg = a_neg && (r_mag != '0);
            a_neg = b_neg;
            a_mag = b_mag;
            b_neg = r_neg;
            b_mag = r_mag;
        end
        if (a_mag == '0) begin
            res.num      = num;
            res.den      = den;
            res.zero_err = 1'b1;
        end else begin
            q            = n_mag / a_mag;
            res.num      = ((n_neg != a_neg) && q != '0) ? -q : q;
            q            = d_mag / a_mag;
            res.den      = ((d_neg != a_neg) && q != '0) ? -q : q;
            res.zero_err = 1'b0;
        end
        return res;
    endfunction

    // Any word except the most negative one, which lies outside the input range
    function automatic t_word rand_word();
        t_word w;
        w = $urandom;
        if (w == {1'b1, {(DATA_WIDTH-1){1'b0}}})
            w = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};
        return w;
    endfunction

    function automatic t_word apply_sign(t_word mag);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_fraction(t_word num, t_word den);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_reductions.push_back(reduce_fraction(num, den));
        n_requests++;
    endtask

    task automatic report_mismatch(string what, t_word exp_val, t_word got_val);
        n_mismatches++;
        if (n_mismatches <= MAX_SHOWN)
            $display("[%0t] %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                     $realtime, what, $signed(exp_val), exp_val, $signed(got_val), got_val);
    endtask

    // Compare each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_reduced exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_reductions.size() == 0) begin
                report_mismatch("unexpected result, num_out", '0,
                                m_axis_tdata[DATA_WIDTH-1:0]);
            end else begin
                exp_res = pending_reductions.pop_front();
                if (exp_res.zero_err)
                    n_zero_flags++;
                if (m_axis_tdata[DATA_WIDTH-1:0] !== exp_res.num)
                    report_mismatch("num_out", exp_res.num, m_axis_tdata[DATA_WIDTH-1:0]);
                if (m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] !== exp_res.den)
                    report_mismatch("den_out", exp_res.den,
                                    m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                if (m_axis_tuser !== exp_res.zero_err)
                    report_mismatch("zero_error", t_word'(exp_res.zero_err),
                                    t_word'(m_axis_tuser));
            end
        end
    end

    // Stall the result side for a random number of cycles once a result shows up
    always @(negedge i_clk) begin
        int rx_hold;
        int rx_seen;
        if (!m_axis_tvalid || n_results != rx_seen) begin
            rx_seen = n_results;
            rx_hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (!m_axis_tvalid) begin
            m_axis_tready <= no_idle ? 1'b1 : 1'($urandom_range(0, 1));
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Zero operands: both zero flags an error, one zero makes the other the gcd
    task automatic test_zero_operands();
        send_fraction(0, 0);
        send_fraction(7, 0);
        send_fraction(-7, 0);
        send_fraction(0, 9);
        send_fraction(0, -9);
        send_fraction(2147483647, 0);
        send_fraction(0, -2147483647);
    endtask

    // Range limits and unit values in every sign combination
    task automatic test_extremes();
        send_fraction(2147483647, 2147483647);
        send_fraction(2147483647, -2147483647);
        send_fraction(-2147483647, 2147483647);
        send_fraction(-2147483647, -2147483647);
        send_fraction(1, 1);
        send_fraction(-1, 1);
        send_fraction(1, -1);
        send_fraction(-1, -1);
        send_fraction(2147483647, 1);
        send_fraction(1, -2147483647);
    endtask

    // Negative gcd from a negative numerator, and the longest Euclid chain
    task automatic test_signs_and_long_chain();
        send_fraction(-6, 4);
        send_fraction(6, -4);
        send_fraction(-6, -4);
        send_fraction(12, 18);
        send_fraction(1836311903, 1134903170);
        send_fraction(-1836311903, 1134903170);
    endtask

    // Full-width random operands
    task automatic test_random_full(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_fraction(rand_word(), rand_word());
        end
    endtask

    // Operands sharing a random factor so the reduction does real work
    task automatic test_random_common_factor(int count);
        int    g_bits;
        t_word g, x, y;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            g_bits = $urandom_range(1, 20);
            g = $urandom_range(1, (1 << g_bits) - 1);
            x = $urandom_range(0, (1 << (30 - g_bits)) - 1);
            y = $urandom_range(0, (1 << (30 - g_bits)) - 1);
            if ($urandom_range(0, 15) == 0)
                x = '0;
            send_fraction(apply_sign(g * x), apply_sign(g * y));
        end
    endtask

    // Small operands, zeros included, for short latencies and frequent corner hits
    task automatic test_random_small(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_fraction(apply_sign($urandom_range(0, 50)), apply_sign($urandom_range(0, 50)));
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        no_idle       = 1'b0;
        n_requests    = 0;
        n_results     = 0;
        n_zero_flags  = 0;
        n_mismatches  = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_operands();
        test_extremes();
        test_signs_and_long_chain();
        test_random_full(600);
        test_random_common_factor(500);
        test_random_small(500);

        // Drop valid, drain outstanding results, then watch for stray ones
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reductions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d fractions (directed zero, extreme and sign cases, then random",
                 n_requests);
        $display("full-width, common-factor and small operands); checked %0d results, %0d flagged",
                 n_results, n_zero_flags);
        if (n_mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_reductions.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
